// ===== hdl/cdl_pkg.sv =====
// cdl_pkg: shared constants, command and status codes, fsm state type
// for the cursor doubly linked list engine; no dependencies
package cdl_pkg;

   localparam int DEF_CAPACITY   = 256;
   localparam int DEF_VALUE_BITS = 32;
   localparam int CMD_BITS       = 3;
   localparam int STATUS_BITS    = 3;
   localparam int COUNT_BITS     = 9;
   localparam int PORT_VALUE_BITS = 32;

   localparam logic [CMD_BITS-1:0] CMD_FIRST   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_LAST    = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_ADVANCE = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_RETREAT = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_INSERT  = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_DELETE  = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SEARCH  = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_AT_END = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_BEFORE = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd4;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_RD    = 7'b0000010,
      S_EXEC  = 7'b0000100,
      S_FIX   = 7'b0001000,
      S_WALK  = 7'b0010000,
      S_LOOK  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

endpackage

// ===== hdl/cdl_node_mem.sv =====
// cdl_node_mem: node memory holding value, next and prev of every node
// one write port per field array, one registered read; uses cdl_pkg
module cdl_node_mem #(
   parameter int CAPACITY   = 256,
   parameter int VALUE_BITS = 32,
   parameter int IDX_BITS   = 8,
   parameter int LINK_BITS  = 9
) (
   input  logic                  clock,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output logic [VALUE_BITS-1:0] rd_value,
   output logic [LINK_BITS-1:0]  rd_next,
   output logic [LINK_BITS-1:0]  rd_prev,
   input  logic                  wv_en,
   input  logic [IDX_BITS-1:0]   wv_addr,
   input  logic [VALUE_BITS-1:0] wv_data,
   input  logic                  wn_en,
   input  logic [IDX_BITS-1:0]   wn_addr,
   input  logic [LINK_BITS-1:0]  wn_data,
   input  logic                  wp_en,
   input  logic [IDX_BITS-1:0]   wp_addr,
   input  logic [LINK_BITS-1:0]  wp_data
);
   import cdl_pkg::*;

   logic [VALUE_BITS-1:0] values [CAPACITY];
   logic [LINK_BITS-1:0]  nexts  [CAPACITY];
   logic [LINK_BITS-1:0]  prevs  [CAPACITY];

   always_ff @(posedge clock) begin
      if (wv_en) values[wv_addr] <= wv_data;
      rd_value <= values[rd_addr];
   end
   always_ff @(posedge clock) begin
      if (wn_en) nexts[wn_addr] <= wn_data;
      rd_next <= nexts[rd_addr];
   end
   always_ff @(posedge clock) begin
      if (wp_en) prevs[wp_addr] <= wp_data;
      rd_prev <= prevs[rd_addr];
   end
endmodule

// ===== hdl/cdl_free_stack.sv =====
// cdl_free_stack: stack of free node indexes; unwritten slots read as their own index
// fill mark gives the reset contents without a clearing pass; uses cdl_pkg
module cdl_free_stack #(
   parameter int CAPACITY  = 256,
   parameter int IDX_BITS  = 8,
   parameter int LINK_BITS = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [LINK_BITS-1:0] top,
   input  logic                 rd_en,
   output logic [IDX_BITS-1:0]  rd_data,
   input  logic                 push,
   input  logic [IDX_BITS-1:0]  push_data
);
   import cdl_pkg::*;

   logic [IDX_BITS-1:0]  slots [CAPACITY];
   // lowest top seen so far: slots below it were never popped and still hold their index
   logic [LINK_BITS-1:0] low_mark_ff, low_mark_in;
   logic [IDX_BITS-1:0]  raw_ff;
   logic                 fresh_ff;
   logic [IDX_BITS-1:0]  fresh_idx_ff;
   logic [IDX_BITS-1:0]  addr;

   assign addr = IDX_BITS'(top - LINK_BITS'(1));

   always_comb begin
      low_mark_in = low_mark_ff;
      if (top < low_mark_ff) low_mark_in = top;
   end

   always_ff @(posedge clock) begin
      if (reset) low_mark_ff <= LINK_BITS'(CAPACITY);
      else       low_mark_ff <= low_mark_in;
   end

   always_ff @(posedge clock) begin
      if (push) slots[top[IDX_BITS-1:0]] <= push_data;
      if (rd_en) begin
         raw_ff       <= slots[addr];
         fresh_ff     <= (top - LINK_BITS'(1)) < low_mark_ff;
         fresh_idx_ff <= addr;
      end
   end

   assign rd_data = fresh_ff ? fresh_idx_ff : raw_ff;
endmodule

// ===== hdl/cursor_doubly_linked_list.sv =====
// cursor_doubly_linked_list: top level, command sequencer over node memory and free stack
// depends on cdl_pkg, cdl_node_mem, cdl_free_stack
//
//  channel | direction | ports                          | handshake
//  req     | in        | req_cmd, req_value             | req_valid / req_ready
//  rsp     | out       | rsp_status .. rsp_visit_count  | rsp_valid / rsp_ready
//
// cursor commands pass S_RD, S_EXEC, S_FIX and S_LOOK: one node memory read of the
// cursor node, the link updates, and a read-back of the new cursor node.
// search walks one node per S_WALK read and S_LOOK compare, then reads back the cursor.
// reset is synchronous and needs no clearing pass; the free stack uses a fill mark.
// one item is in flight; req_ready is high only when no result is pending.
module cursor_doubly_linked_list #(
   parameter int CAPACITY   = cdl_pkg::DEF_CAPACITY,
   parameter int VALUE_BITS = cdl_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [cdl_pkg::CMD_BITS-1:0]         req_cmd,
   input  logic signed [cdl_pkg::PORT_VALUE_BITS-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [cdl_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [cdl_pkg::COUNT_BITS-1:0]       rsp_length,
   output logic                                 rsp_at_end,
   output logic                                 rsp_current_valid,
   output logic signed [cdl_pkg::PORT_VALUE_BITS-1:0] rsp_current_value,
   output logic                                 rsp_found,
   output logic [cdl_pkg::COUNT_BITS-1:0]       rsp_visit_count
);
   import cdl_pkg::*;

   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int LINK_BITS = $clog2(CAPACITY + 1);
   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(CAPACITY);
   localparam int PV = PORT_VALUE_BITS;

   state_type state_ff, state_in;

   logic [CMD_BITS-1:0]   cmd_ff, cmd_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [LINK_BITS-1:0]  head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [LINK_BITS-1:0]  count_ff, count_in, top_ff, top_in;
   logic [LINK_BITS-1:0]  walk_ff, walk_in, visits_ff, visits_in;
   logic [LINK_BITS-1:0]  aux_ff, aux_in;      // node whose prev, or next for an insert at the cursor, must be fixed
   logic [LINK_BITS-1:0]  auxv_ff, auxv_in;
   logic                  fix_ff, fix_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                  found_ff, found_in;

   logic [IDX_BITS-1:0]   rd_addr;
   logic [VALUE_BITS-1:0] rd_value;
   logic [LINK_BITS-1:0]  rd_next, rd_prev;
   logic                  wv_en, wn_en, wp_en;
   logic [IDX_BITS-1:0]   wv_addr, wn_addr, wp_addr;
   logic [LINK_BITS-1:0]  wn_data, wp_data;
   logic                  fs_rd, fs_push;
   logic [IDX_BITS-1:0]   fs_data, fs_push_data;

   // registered result
   logic                  rv_ff, rv_in;
   logic [STATUS_BITS-1:0] o_status_ff, o_status_in;
   logic [COUNT_BITS-1:0] o_len_ff, o_len_in, o_vis_ff, o_vis_in;
   logic                  o_end_ff, o_end_in, o_cv_ff, o_cv_in, o_found_ff, o_found_in;
   logic [VALUE_BITS-1:0] o_val_ff, o_val_in;

   logic                  cur_node, accept;
   logic [LINK_BITS-1:0]  k_link;

   assign cur_node = cur_ff < NIL;
   assign accept   = req_valid && req_ready;
   assign req_ready = state_ff == S_IDLE && !rv_ff;
   assign k_link   = LINK_BITS'(fs_data);

   cdl_node_mem #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS),
                  .IDX_BITS(IDX_BITS), .LINK_BITS(LINK_BITS)) u_mem (
      .clock, .rd_addr, .rd_value, .rd_next, .rd_prev,
      .wv_en, .wv_addr, .wv_data(val_ff),
      .wn_en, .wn_addr, .wn_data, .wp_en, .wp_addr, .wp_data);

   cdl_free_stack #(.CAPACITY(CAPACITY), .IDX_BITS(IDX_BITS),
                    .LINK_BITS(LINK_BITS)) u_free (
      .clock, .reset, .top(top_ff), .rd_en(fs_rd), .rd_data(fs_data),
      .push(fs_push), .push_data(fs_push_data));

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; val_in = val_ff;
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff;
      count_in = count_ff; top_in = top_ff; walk_in = walk_ff;
      visits_in = visits_ff; aux_in = aux_ff; auxv_in = auxv_ff; fix_in = fix_ff;
      status_in = status_ff; found_in = found_ff;
      rd_addr = cur_ff[IDX_BITS-1:0];
      wv_en = 1'b0; wn_en = 1'b0; wp_en = 1'b0;
      wv_addr = k_link[IDX_BITS-1:0]; wn_addr = '0; wp_addr = '0;
      wn_data = '0; wp_data = '0;
      fs_rd = 1'b0; fs_push = 1'b0; fs_push_data = cur_ff[IDX_BITS-1:0];
      rv_in = rv_ff; o_status_in = o_status_ff; o_len_in = o_len_ff;
      o_vis_in = o_vis_ff; o_end_in = o_end_ff; o_cv_in = o_cv_ff;
      o_found_in = o_found_ff; o_val_in = o_val_ff;

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               val_in = VALUE_BITS'(req_value);
               status_in = ST_OK; found_in = 1'b0; visits_in = '0; fix_in = 1'b0;
               walk_in = head_ff;
               fs_rd = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            // cursor node links now in flight; free stack top too
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_FIX;
            case (cmd_ff)
               CMD_FIRST, CMD_LAST: begin
                  if (count_ff == '0) status_in = ST_EMPTY;
                  else cur_in = (cmd_ff == CMD_FIRST) ? head_ff : tail_ff;
               end
               CMD_ADVANCE: begin
                  if (cur_node) begin
                     if (rd_next < NIL) cur_in = rd_next;
                     else status_in = ST_AT_END;
                  end else if (count_ff != '0) cur_in = head_ff;
                  else status_in = ST_EMPTY;
               end
               CMD_RETREAT: begin
                  if (cur_node) cur_in = rd_prev;
                  else status_in = (count_ff != '0) ? ST_BEFORE : ST_EMPTY;
               end
               CMD_INSERT: begin
                  if (top_ff == '0) status_in = ST_FULL;
                  else begin
                     top_in = top_ff - LINK_BITS'(1);
                     count_in = count_ff + LINK_BITS'(1);
                     wv_en = 1'b1;
                     wn_en = 1'b1; wn_addr = k_link[IDX_BITS-1:0];
                     wp_en = 1'b1; wp_addr = k_link[IDX_BITS-1:0];
                     if (!cur_node) begin
                        wn_data = head_ff; wp_data = NIL;
                        head_in = k_link;
                        if (head_ff < NIL) begin
                           fix_in = 1'b1; aux_in = head_ff; auxv_in = k_link;
                        end else tail_in = k_link;
                     end else begin
                        wn_data = rd_next; wp_data = cur_ff;
                        fix_in = 1'b1;
                        aux_in = cur_ff; auxv_in = k_link; // next of cursor
                        if (rd_next < NIL) walk_in = rd_next;
                        else begin
                           tail_in = k_link; walk_in = NIL;
                        end
                     end
                  end
               end
               CMD_DELETE: begin
                  if (!cur_node) status_in = (count_ff != '0) ? ST_BEFORE : ST_EMPTY;
                  else begin
                     if (rd_prev < NIL) begin
                        wn_en = 1'b1; wn_addr = rd_prev[IDX_BITS-1:0]; wn_data = rd_next;
                     end else head_in = rd_next;
                     if (rd_next < NIL) begin
                        wp_en = 1'b1; wp_addr = rd_next[IDX_BITS-1:0]; wp_data = rd_prev;
                     end else tail_in = rd_prev;
                     cur_in = (rd_next < NIL) ? rd_next : rd_prev;
                     if (top_ff < NIL) begin
                        fs_push = 1'b1; top_in = top_ff + LINK_BITS'(1);
                     end
                     if (count_ff != '0) count_in = count_ff - LINK_BITS'(1);
                  end
               end
               CMD_SEARCH: state_in = S_WALK;
               default: ;
            endcase
         end
         S_FIX: begin
            // second link write of an insert, then read the cursor node
            if (fix_ff) begin
               if (cmd_ff == CMD_INSERT && aux_ff == cur_ff && cur_node) begin
                  wn_en = 1'b1; wn_addr = cur_ff[IDX_BITS-1:0]; wn_data = auxv_ff;
                  if (walk_ff < NIL) begin
                     wp_en = 1'b1; wp_addr = walk_ff[IDX_BITS-1:0]; wp_data = auxv_ff;
                  end
               end else begin
                  wp_en = 1'b1; wp_addr = aux_ff[IDX_BITS-1:0]; wp_data = auxv_ff;
               end
               fix_in = 1'b0;
            end else begin
               rd_addr = cur_ff[IDX_BITS-1:0];
               state_in = S_LOOK;
            end
         end
         S_WALK: begin
            if (walk_ff < NIL && visits_ff < NIL) begin
               rd_addr = walk_ff[IDX_BITS-1:0];
               state_in = S_LOOK;
            end else begin
               rd_addr = cur_ff[IDX_BITS-1:0];
               cmd_in = CMD_FIRST; // walk over, only the cursor read remains
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (cmd_ff == CMD_SEARCH) begin
               visits_in = visits_ff + LINK_BITS'(1);
               if (rd_value == val_ff) begin
                  found_in = 1'b1; cmd_in = CMD_FIRST;
                  rd_addr = cur_ff[IDX_BITS-1:0];
                  state_in = S_OUT;
               end else begin
                  walk_in = rd_next;
                  state_in = S_WALK;
               end
            end else begin
               state_in = S_OUT;
               o_status_in = status_ff;
               o_len_in = COUNT_BITS'(count_ff);
               o_cv_in = cur_node;
               o_end_in = cur_node && !(rd_next < NIL);
               o_val_in = cur_node ? rd_value : '0;
               o_found_in = found_ff;
               o_vis_in = COUNT_BITS'(visits_ff);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            // cursor read issued after a search hit
            state_in = S_LOOK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0;
         head_ff <= NIL; tail_ff <= NIL; cur_ff <= NIL;
         count_ff <= '0; top_ff <= NIL; fix_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rv_ff <= rv_in;
         head_ff <= head_in; tail_ff <= tail_in; cur_ff <= cur_in;
         count_ff <= count_in; top_ff <= top_in; fix_ff <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; val_ff <= val_in; walk_ff <= walk_in;
      visits_ff <= visits_in; aux_ff <= aux_in; auxv_ff <= auxv_in;
      status_ff <= status_in; found_ff <= found_in;
      o_status_ff <= o_status_in; o_len_ff <= o_len_in; o_vis_ff <= o_vis_in;
      o_end_ff <= o_end_in; o_cv_ff <= o_cv_in; o_found_ff <= o_found_in;
      o_val_ff <= o_val_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = o_status_ff;
   assign rsp_length = o_len_ff;
   assign rsp_at_end = o_end_ff;
   assign rsp_current_valid = o_cv_ff;
   assign rsp_current_value = PV'(o_val_ff);
   assign rsp_found = o_found_ff;
   assign rsp_visit_count = o_vis_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NIL) else $error("element count above capacity");
   a_free_sum: assert property (@(posedge clock) disable iff (reset)
      (count_ff + top_ff) == NIL) else $error("free stack and count disagree");
   a_empty_nil: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && count_ff == '0 |-> head_ff == NIL && cur_ff == NIL)
      else $error("empty list with live head or cursor");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("second item taken while busy");
endmodule
